### sv/mlh_pkg.sv
// Package for the line hull max query block: sizes, codes, item and link types.
`default_nettype none
package mlh_pkg;
    localparam int HULL_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(HULL_DEPTH);
    localparam int CNT_W      = $clog2(HULL_DEPTH + 1);
    localparam int OPD_W      = 25;
    localparam int PROD_W     = 2 * OPD_W;
    localparam int ACC_W      = 76;
    localparam int HALF_SH    = 24;
    localparam int N_CELLS    = 4;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE, S_ARD1, S_ARD2, S_ACALC, S_AWAIT, S_AWR,
        S_QCHK, S_QRD2, S_QCALC, S_QWAIT, S_QFRD, S_QFCALC, S_QFWAIT, S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] slope;
        logic signed [47:0] intercept;
        logic signed [23:0] query_x;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] max_value;
        logic               hull_empty;
        logic               add_dropped;
    } t_out_item;

    // partial sum passed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } t_link;

    // per-cell product term: +/- a*b, optionally shifted up by HALF_SH
    typedef struct packed {
        logic signed [OPD_W-1:0] a;
        logic signed [OPD_W-1:0] b;
        logic                    sh;
        logic                    neg;
    } t_op;
endpackage
`default_nettype wire

### sv/monotone_line_hull_max_query_top.sv
// Top level: line stack memory, control sequencer and the cell chain.
//
//  channel | signals                              | carries
//  in      | i_in_valid, o_in_stall, i_in_item    | add / query / clear item
//  out     | o_out_valid, i_out_stall, o_out_item | one result per item
//  cfg     | i_cfg_we, i_cfg_wdata                | slope_order
//
// One item at a time. Clear, unused codes and dropped adds go straight to the output; an add
// to fewer than two lines is written at once. Each pop test of an add does 2 memory
// reads, loads the cell operands and waits until the sum leaves the 4 cells.
// A query runs a binary search (each step reads two lines and evaluates them, but for a
// step at index 0), then reads and evaluates the chosen line and loads the result.
// Reset empties the stack; memory contents need no clearing.
// A stalled result keeps the next one in the block, which then stalls its input.
`default_nettype none
module monotone_line_hull_max_query_top
    import mlh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);
    logic signed [23:0] mem_s [HULL_DEPTH];
    logic signed [47:0] mem_i [HULL_DEPTH];
    logic signed [23:0] r_rd_s;
    logic signed [47:0] r_rd_i;
    logic [ADDR_W-1:0]  rd_addr;
    logic               we;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count, r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic r_order;
    t_in_item r_item, n_item;
    logic signed [23:0] r_ls, n_ls;
    logic signed [47:0] r_li, n_li;
    t_out_item r_pend, n_pend, r_out, n_out;
    logic r_out_valid, n_out_valid;
    t_op r_ops [N_CELLS];
    t_op n_ops [N_CELLS];
    logic signed [ACC_W-1:0] r_acc0, n_acc0;
    logic r_start, n_start;
    t_link links [N_CELLS+1];

    logic signed [OPD_W-1:0] k25, x25, dk1, dk2;
    logic signed [48:0] db1, db2;
    logic signed [ACC_W-1:0] res;
    logic [CNT_W-1:0] mid_c;
    logic pop;

    assign links[0] = '{valid: r_start, acc: r_acc0};

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        mlh_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_link (links[g]),
            .i_op   (r_ops[g]),
            .o_link (links[g+1])
        );
    end

    assign res = links[N_CELLS].acc;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_s[r_count[ADDR_W-1:0]] <= r_item.slope;
            mem_i[r_count[ADDR_W-1:0]] <= r_item.intercept;
        end
        r_rd_s <= mem_s[rd_addr];
        r_rd_i <= mem_i[rd_addr];
    end

    always_comb begin
        k25   = {r_item.slope[23], r_item.slope};
        x25   = {r_item.query_x[23], r_item.query_x};
        dk1   = k25 - {r_ls[23], r_ls};
        db1   = {r_item.intercept[47], r_item.intercept} - {r_li[47], r_li};
        dk2   = k25 - {r_rd_s[23], r_rd_s};
        db2   = {r_item.intercept[47], r_item.intercept} - {r_rd_i[47], r_rd_i};
        mid_c = r_lo + ((r_hi - r_lo) >> 1);
        pop   = r_order ? !res[ACC_W-1] : (res[ACC_W-1] || (res == '0));

        n_state = r_state;
        n_count = r_count;
        n_lo = r_lo;
        n_hi = r_hi;
        n_mid = r_mid;
        n_item = r_item;
        n_ls = r_ls;
        n_li = r_li;
        n_pend = r_pend;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_ops = r_ops;
        n_acc0 = r_acc0;
        n_start = 1'b0;
        rd_addr = '0;
        we = 1'b0;
        o_in_stall = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_pend = '0;
                    n_state = S_OUT;
                    unique case (t_action'(i_in_item.action))
                        ACT_ADD: begin
                            if (r_count >= CNT_W'(HULL_DEPTH)) begin
                                n_pend.add_dropped = 1'b1;
                            end else if (r_count > CNT_W'(1)) begin
                                n_state = S_ARD1;
                            end else begin
                                n_state = S_AWR;
                            end
                        end
                        ACT_QUERY: begin
                            if (r_count == '0) begin
                                n_pend.hull_empty = 1'b1;
                            end else begin
                                n_lo = '0;
                                n_hi = r_count;
                                n_state = S_QCHK;
                            end
                        end
                        ACT_CLEAR: n_count = '0;
                        ACT_NONE: ;
                    endcase
                end
            end
            S_ARD1: begin
                rd_addr = ADDR_W'(r_count - CNT_W'(1));
                n_state = S_ARD2;
            end
            S_ARD2: begin
                n_ls = r_rd_s;
                n_li = r_rd_i;
                rd_addr = ADDR_W'(r_count - CNT_W'(2));
                n_state = S_ACALC;
            end
            S_ACALC: begin
                // dk1*db2 - db1*dk2, with db split into low and high halves
                n_ops[0] = '{a: dk1, b: {1'b0, db2[23:0]}, sh: 1'b0, neg: 1'b0};
                n_ops[1] = '{a: dk1, b: db2[48:24],        sh: 1'b1, neg: 1'b0};
                n_ops[2] = '{a: dk2, b: {1'b0, db1[23:0]}, sh: 1'b0, neg: 1'b1};
                n_ops[3] = '{a: dk2, b: db1[48:24],        sh: 1'b1, neg: 1'b1};
                n_acc0 = '0;
                n_start = 1'b1;
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                if (links[N_CELLS].valid) begin
                    if (pop) begin
                        n_count = r_count - CNT_W'(1);
                        n_state = (r_count > CNT_W'(2)) ? S_ARD1 : S_AWR;
                    end else begin
                        n_state = S_AWR;
                    end
                end
            end
            S_AWR: begin
                we = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = S_OUT;
            end
            S_QCHK: begin
                if (r_lo == r_hi) begin
                    rd_addr = ADDR_W'(r_hi - CNT_W'(1));
                    n_state = S_QFRD;
                end else if (mid_c == '0) begin
                    n_lo = mid_c + CNT_W'(1);
                end else begin
                    n_mid = mid_c;
                    rd_addr = ADDR_W'(mid_c);
                    n_state = S_QRD2;
                end
            end
            S_QRD2: begin
                n_ls = r_rd_s;
                n_li = r_rd_i;
                rd_addr = ADDR_W'(r_mid - CNT_W'(1));
                n_state = S_QCALC;
            end
            S_QCALC: begin
                n_acc0 = ACC_W'(r_li) - ACC_W'(r_rd_i);
                n_ops[0] = '{a: {r_ls[23], r_ls}, b: x25, sh: 1'b0, neg: 1'b0};
                n_ops[1] = '{a: {r_rd_s[23], r_rd_s}, b: x25, sh: 1'b0, neg: 1'b1};
                n_ops[2] = '0;
                n_ops[3] = '0;
                n_start = 1'b1;
                n_state = S_QWAIT;
            end
            S_QWAIT: begin
                if (links[N_CELLS].valid) begin
                    if (!res[ACC_W-1]) begin
                        n_lo = r_mid + CNT_W'(1);
                    end else begin
                        n_hi = r_mid;
                    end
                    n_state = S_QCHK;
                end
            end
            S_QFRD: begin
                // keep the answer line on the read port while S_QFCALC loads it
                rd_addr = ADDR_W'(r_hi - CNT_W'(1));
                n_state = S_QFCALC;
            end
            S_QFCALC: begin
                n_acc0 = ACC_W'(r_rd_i);
                n_ops[0] = '{a: {r_rd_s[23], r_rd_s}, b: x25, sh: 1'b0, neg: 1'b0};
                n_ops[1] = '0;
                n_ops[2] = '0;
                n_ops[3] = '0;
                n_start = 1'b1;
                n_state = S_QFWAIT;
            end
            S_QFWAIT: begin
                if (links[N_CELLS].valid) begin
                    n_pend.max_value = res[63:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = r_pend;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_valid <= 1'b0;
            r_start <= 1'b0;
            r_order <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_out_valid <= n_out_valid;
            r_start <= n_start;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_mid <= n_mid;
        r_item <= n_item;
        r_ls <= n_ls;
        r_li <= n_li;
        r_pend <= n_pend;
        r_out <= n_out;
        r_ops <= n_ops;
        r_acc0 <= n_acc0;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire

### sv/mlh_cell.sv
// One multiply-accumulate cell of the cross product / line value chain.
`default_nettype none
module mlh_cell
    import mlh_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_link i_link,
    input  wire t_op   i_op,
    output t_link      o_link
);
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  term_sh;
    t_link r_link;

    always_comb begin
        prod    = i_op.a * i_op.b;
        term    = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        term_sh = i_op.sh ? (term <<< HALF_SH) : term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
        end else begin
            r_link.valid <= i_link.valid;
        end
        r_link.acc <= i_op.neg ? (i_link.acc - term_sh) : (i_link.acc + term_sh);
    end

    assign o_link = r_link;
endmodule
`default_nettype wire

### sv/mlh_checker.sv
// Port-level checks for the line hull top, bound to every instance.
`default_nettype none
module mlh_checker
    import mlh_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.hull_empty && o_out_item.add_dropped))
        else $error("both flags set");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.hull_empty || o_out_item.add_dropped)
            |-> o_out_item.max_value == '0)
        else $error("flagged result carries a value");
endmodule

bind monotone_line_hull_max_query_top mlh_checker u_mlh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
`default_nettype wire
